### hdl/esat_pkg.sv
// ---------------------------------------------------------------------------
// esat_pkg: shared types and constants of the acceleration tracker
// Register indexes, fixed arithmetic constants and the command and status
// bundles that join the controller to the datapath.
// ---------------------------------------------------------------------------
`default_nettype none

package esat_pkg;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_ENABLED     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CRANK_THR   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CRANK_COEFF = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_NORM_COEFF  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_ACCEL_THR   = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_INTV    = 3'd5;

    // Widths of fields and registers.
    localparam int unsigned CFG_DATA_W = 24;
    localparam int unsigned RPM_W      = 16;
    localparam int unsigned TIME_W     = 32;
    localparam int unsigned COEFF_W    = 17;
    localparam int unsigned INTV_W     = 24;
    localparam int unsigned ACCEL_W    = 32;

    // Arithmetic constants.
    localparam int unsigned US_PER_S_W = 20;
    localparam logic [US_PER_S_W-1:0] US_PER_S = 20'd1000000;
    localparam int unsigned PROD_W     = RPM_W + US_PER_S_W;
    localparam int unsigned DIV_STEPS  = PROD_W;
    localparam int unsigned DIV_CNT_W  = $clog2(DIV_STEPS);

    localparam logic [COEFF_W-1:0] COEFF_MAX   = 17'd65536;
    localparam logic [INTV_W-1:0]  INTERVAL_LO = 24'd1000;
    localparam logic [INTV_W-1:0]  INTERVAL_HI = 24'd10000000;

    // Reset values of the configuration registers.
    localparam logic [RPM_W-1:0]   RST_CRANK_THR   = 16'd400;
    localparam logic [COEFF_W-1:0] RST_CRANK_COEFF = 17'd13107;
    localparam logic [COEFF_W-1:0] RST_NORM_COEFF  = 17'd3277;
    localparam logic [RPM_W-1:0]   RST_ACCEL_THR   = 16'd50;
    localparam logic [INTV_W-1:0]  RST_MIN_INTV    = 24'd100000;

    typedef struct packed {
        logic load;      // capture an input beat
        logic eval;      // elapsed time, product and decision
        logic div_step;  // one quotient bit
        logic finish;    // commit state and load the output register
    } esat_cmd_t;

    typedef struct packed {
        logic go_div;    // this item produces a new acceleration
        logic div_last;  // the final quotient bit is being formed
        logic out_free;  // the output register can take a beat
    } esat_status_t;

endpackage

`default_nettype wire

### hdl/esat_in_if.sv
// ---------------------------------------------------------------------------
// esat_in_if: input channel of the acceleration tracker
// One beat carries a speed sample and its microsecond timestamp.
// ---------------------------------------------------------------------------
`default_nettype none

interface esat_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] speed_rpm;
    logic [31:0] timestamp_us;

    modport source (output valid, output speed_rpm, output timestamp_us, input ready);
    modport sink   (input valid, input speed_rpm, input timestamp_us, output ready);
endinterface

`default_nettype wire

### hdl/esat_out_if.sv
// ---------------------------------------------------------------------------
// esat_out_if: result channel of the acceleration tracker
// One beat carries the acceleration estimate, its flags and the coefficient.
// ---------------------------------------------------------------------------
`default_nettype none

interface esat_out_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] acceleration;
    logic               accelerating;
    logic               decelerating;
    logic               cranking;
    logic [16:0]        active_coeff;
    logic               accel_updated;

    modport source (output valid, output acceleration, output accelerating,
                    output decelerating, output cranking, output active_coeff,
                    output accel_updated, input ready);
    modport sink   (input valid, input acceleration, input accelerating,
                    input decelerating, input cranking, input active_coeff,
                    input accel_updated, output ready);
endinterface

`default_nettype wire

### hdl/engine_speed_acceleration_tracker_core.sv
// A result beat turns valid after its item has passed the evaluation state,
// the division state when a new acceleration is computed, and the commit state.
// A new input beat is taken only after the previous item is committed; the
// 36-step bit-serial divider that forms the quotient makes the longer path.
// Reset (rst_n, asynchronous, active low) restores the register defaults,
// disables tracking and clears the reference and the held acceleration.
// ---------------------------------------------------------------------------
// engine_speed_acceleration_tracker_core: engine acceleration tracker
// Estimates rpm per second from timestamped speed samples, flags
// acceleration and deceleration, and selects the filter coefficient.
// ---------------------------------------------------------------------------
`default_nettype none

module engine_speed_acceleration_tracker_core (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            cfg_wr_en,
    input  wire logic [esat_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [esat_pkg::CFG_DATA_W-1:0] cfg_wr_data,
    esat_in_if.sink                              in_beat,
    esat_out_if.source                           out_beat
);

    // The controller walks each accepted beat through capture, evaluation,
    // division when a new acceleration is computed, and commit. The datapath
    // owns every register that holds data, including the configuration
    // registers and the output register, and reports back only the few status
    // bits the controller needs to pick its next phase.
    esat_pkg::esat_cmd_t    cmd;
    esat_pkg::esat_status_t status;

    esat_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (in_beat.valid),
        .in_ready (in_beat.ready),
        .status   (status),
        .cmd      (cmd)
    );

    // In the evaluation phase the datapath forms the wrapped elapsed time,
    // decides whether the interval has been reached and registers the scaled
    // speed difference |delta| * 1000000 as the dividend. The divider then
    // produces one quotient bit per cycle; the sign is restored and the
    // value saturated when the result is committed. Because the output
    // register sits between the sides, a new beat is taken while the
    // previous result still waits for the sink.
    esat_dp u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wr_data   (cfg_wr_data),
        .speed_rpm     (in_beat.speed_rpm),
        .timestamp_us  (in_beat.timestamp_us),
        .cmd           (cmd),
        .status        (status),
        .out_ready     (out_beat.ready),
        .out_valid     (out_beat.valid),
        .acceleration  (out_beat.acceleration),
        .accelerating  (out_beat.accelerating),
        .decelerating  (out_beat.decelerating),
        .cranking      (out_beat.cranking),
        .active_coeff  (out_beat.active_coeff),
        .accel_updated (out_beat.accel_updated)
    );

`ifndef SYNTHESIS
    // An accepted beat is evaluated in the very next cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat.valid && in_beat.ready) |=> cmd.eval)
    else $error("accepted beat was not evaluated next cycle");

    // A commit always presents a result beat.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.finish |=> out_beat.valid)
    else $error("commit did not produce a result beat");

    // The threshold is never negative, so both flags cannot be set at once.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_beat.valid |-> !(out_beat.accelerating && out_beat.decelerating))
    else $error("acceleration and deceleration flagged together");

    // Coefficient writes are clamped, so the selected one stays in range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_beat.valid |-> (out_beat.active_coeff <= esat_pkg::COEFF_MAX))
    else $error("active coefficient out of range");
`endif

endmodule

`default_nettype wire

### hdl/esat_ctrl.sv
// ---------------------------------------------------------------------------
// esat_ctrl: sequencer of the acceleration tracker
// Steps one item through capture, evaluation, division (when a new acceleration is computed) and commit.
// ---------------------------------------------------------------------------
`default_nettype none

module esat_ctrl (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_ready,
    input  wire esat_pkg::esat_status_t status,
    output esat_pkg::esat_cmd_t        cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_EVAL = 2'd1;
    localparam logic [1:0] ST_DIV  = 2'd2;
    localparam logic [1:0] ST_FIN  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                    state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                state_next = status.go_div ? ST_DIV : ST_FIN;
            end
            ST_DIV:
            begin
                if (status.div_last)
                    state_next = ST_FIN;
            end
            ST_FIN:
            begin
                if (status.out_free)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= ST_IDLE;
        else
            state_reg <= state_next;
    end

    assign in_ready     = (state_reg == ST_IDLE);
    assign cmd.load     = (state_reg == ST_IDLE) && in_valid;
    assign cmd.eval     = (state_reg == ST_EVAL);
    assign cmd.div_step = (state_reg == ST_DIV);
    assign cmd.finish   = (state_reg == ST_FIN) && status.out_free;

endmodule

`default_nettype wire

### hdl/esat_dp.sv
// ---------------------------------------------------------------------------
// esat_dp: datapath of the acceleration tracker
// Configuration registers, reference state, multiplier, bit-serial divider
// and the output register.
// ---------------------------------------------------------------------------
`default_nettype none

module esat_dp (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_wr_en,
    input  wire logic [esat_pkg::CFG_IDX_W-1:0]        cfg_index,
    input  wire logic [esat_pkg::CFG_DATA_W-1:0]       cfg_wr_data,
    input  wire logic [esat_pkg::RPM_W-1:0]            speed_rpm,
    input  wire logic [esat_pkg::TIME_W-1:0]           timestamp_us,
    input  wire esat_pkg::esat_cmd_t                   cmd,
    output esat_pkg::esat_status_t                     status,
    input  wire logic                                  out_ready,
    output logic                                       out_valid,
    output logic signed [esat_pkg::ACCEL_W-1:0]        acceleration,
    output logic                                       accelerating,
    output logic                                       decelerating,
    output logic                                       cranking,
    output logic [esat_pkg::COEFF_W-1:0]               active_coeff,
    output logic                                       accel_updated
);

    localparam int unsigned PW = esat_pkg::PROD_W;
    localparam int unsigned TW = esat_pkg::TIME_W;

    // Configuration registers.
    logic                           enabled_reg;
    logic [esat_pkg::RPM_W-1:0]     crank_thr_reg;
    logic [esat_pkg::COEFF_W-1:0]   crank_coeff_reg;
    logic [esat_pkg::COEFF_W-1:0]   norm_coeff_reg;
    logic [esat_pkg::RPM_W-1:0]     accel_thr_reg;
    logic [esat_pkg::INTV_W-1:0]    min_intv_reg;

    // Tracking state.
    logic                           seeded_reg;
    logic [esat_pkg::RPM_W-1:0]     ref_speed_reg;
    logic [TW-1:0]                  ref_time_reg;
    logic [esat_pkg::ACCEL_W-1:0]   accel_value_reg;
    logic                           accel_flag_reg;
    logic                           decel_flag_reg;

    // Item in flight.
    logic [esat_pkg::RPM_W-1:0]     rpm_reg;
    logic [TW-1:0]                  now_reg;
    logic                           upd_reg;
    logic                           seed_reg;
    logic                           neg_reg;
    logic [TW-1:0]                  divisor_reg;
    logic [TW-1:0]                  rem_reg;
    logic [PW-1:0]                  quo_reg;
    logic [esat_pkg::DIV_CNT_W-1:0] cnt_reg;

    // Output register.
    logic                           out_valid_reg;
    logic [esat_pkg::ACCEL_W-1:0]   out_accel_reg;
    logic                           out_acc_flag_reg;
    logic                           out_dec_flag_reg;
    logic                           out_crank_reg;
    logic [esat_pkg::COEFF_W-1:0]   out_coeff_reg;
    logic                           out_upd_reg;

    logic [esat_pkg::COEFF_W-1:0]   wr_coeff;
    logic [esat_pkg::INTV_W-1:0]    wr_intv;
    logic [TW-1:0]                  elapsed;
    logic signed [esat_pkg::RPM_W:0] delta;
    logic [esat_pkg::RPM_W-1:0]     delta_mag;
    logic [PW-1:0]                  product;
    logic [TW:0]                    trial;
    logic                           trial_ok;
    logic [esat_pkg::ACCEL_W-1:0]   q_sat;
    logic signed [esat_pkg::ACCEL_W:0] q_ext;
    logic signed [esat_pkg::ACCEL_W:0] thr_ext;
    logic                           crank_now;

    // Write-side clamping of the coefficient and interval registers.
    always_comb
    begin
        wr_coeff = cfg_wr_data[esat_pkg::COEFF_W-1:0];
        if (wr_coeff > esat_pkg::COEFF_MAX)
            wr_coeff = esat_pkg::COEFF_MAX;
        wr_intv = cfg_wr_data[esat_pkg::INTV_W-1:0];
        if (wr_intv < esat_pkg::INTERVAL_LO)
            wr_intv = esat_pkg::INTERVAL_LO;
        else if (wr_intv > esat_pkg::INTERVAL_HI)
            wr_intv = esat_pkg::INTERVAL_HI;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg     <= 1'b0;
            crank_thr_reg   <= esat_pkg::RST_CRANK_THR;
            crank_coeff_reg <= esat_pkg::RST_CRANK_COEFF;
            norm_coeff_reg  <= esat_pkg::RST_NORM_COEFF;
            accel_thr_reg   <= esat_pkg::RST_ACCEL_THR;
            min_intv_reg    <= esat_pkg::RST_MIN_INTV;
        end
        else if (cfg_wr_en)
        begin
            unique case (cfg_index)
                esat_pkg::REG_ENABLED:     enabled_reg     <= cfg_wr_data[0];
                esat_pkg::REG_CRANK_THR:   crank_thr_reg   <= cfg_wr_data[esat_pkg::RPM_W-1:0];
                esat_pkg::REG_CRANK_COEFF: crank_coeff_reg <= wr_coeff;
                esat_pkg::REG_NORM_COEFF:  norm_coeff_reg  <= wr_coeff;
                esat_pkg::REG_ACCEL_THR:   accel_thr_reg   <= cfg_wr_data[esat_pkg::RPM_W-1:0];
                esat_pkg::REG_MIN_INTV:    min_intv_reg    <= wr_intv;
                default:
                begin
                end
            endcase
        end
    end

    // Evaluation: elapsed time, speed difference and scaled magnitude.
    assign elapsed   = now_reg - ref_time_reg;
    assign delta     = $signed({1'b0, rpm_reg}) - $signed({1'b0, ref_speed_reg});
    assign delta_mag = delta[esat_pkg::RPM_W] ? esat_pkg::RPM_W'(-delta)
                                              : esat_pkg::RPM_W'(delta);
    assign product   = PW'(delta_mag) * PW'(esat_pkg::US_PER_S);

    assign status.go_div = enabled_reg && seeded_reg
                        && (elapsed >= {{(TW-esat_pkg::INTV_W){1'b0}}, min_intv_reg});

    // Restoring division, one quotient bit per cycle.
    assign trial    = {rem_reg, quo_reg[PW-1]} - {1'b0, divisor_reg};
    assign trial_ok = !trial[TW];
    assign status.div_last = (cnt_reg == esat_pkg::DIV_CNT_W'(esat_pkg::DIV_STEPS - 1));

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            rpm_reg <= speed_rpm;
            now_reg <= timestamp_us;
        end
        if (cmd.eval)
        begin
            upd_reg     <= status.go_div;
            seed_reg    <= enabled_reg && !seeded_reg;
            neg_reg     <= delta[esat_pkg::RPM_W];
            divisor_reg <= elapsed;
            rem_reg     <= '0;
            quo_reg     <= product;
            cnt_reg     <= '0;
        end
        else if (cmd.div_step)
        begin
            if (trial_ok)
                rem_reg <= trial[TW-1:0];
            else
                rem_reg <= {rem_reg[TW-2:0], quo_reg[PW-1]};
            quo_reg <= {quo_reg[PW-2:0], trial_ok};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    // Sign, saturation and threshold compare of the quotient.
    always_comb
    begin
        if (!neg_reg)
        begin
            if (quo_reg[PW-1:esat_pkg::ACCEL_W-1] != '0)
                q_sat = {1'b0, {(esat_pkg::ACCEL_W-1){1'b1}}};
            else
                q_sat = quo_reg[esat_pkg::ACCEL_W-1:0];
        end
        else
        begin
            if ((quo_reg[PW-1:esat_pkg::ACCEL_W] != '0)
                || (quo_reg[esat_pkg::ACCEL_W-1] && (quo_reg[esat_pkg::ACCEL_W-2:0] != '0)))
                q_sat = {1'b1, {(esat_pkg::ACCEL_W-1){1'b0}}};
            else
                q_sat = -quo_reg[esat_pkg::ACCEL_W-1:0];
        end
    end

    assign q_ext     = $signed({q_sat[esat_pkg::ACCEL_W-1], q_sat});
    assign thr_ext   = $signed({{(esat_pkg::ACCEL_W+1-esat_pkg::RPM_W){1'b0}}, accel_thr_reg});
    assign crank_now = (rpm_reg < crank_thr_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seeded_reg      <= 1'b0;
            ref_speed_reg   <= '0;
            ref_time_reg    <= '0;
            accel_value_reg <= '0;
            accel_flag_reg  <= 1'b0;
            decel_flag_reg  <= 1'b0;
        end
        else if (cmd.finish)
        begin
            if (seed_reg)
            begin
                seeded_reg    <= 1'b1;
                ref_speed_reg <= rpm_reg;
                ref_time_reg  <= now_reg;
            end
            else if (upd_reg)
            begin
                ref_speed_reg   <= rpm_reg;
                ref_time_reg    <= now_reg;
                accel_value_reg <= q_sat;
                accel_flag_reg  <= (q_ext > thr_ext);
                decel_flag_reg  <= (q_ext < -thr_ext);
            end
        end
    end

    // Output register: a result may wait here while the next item is taken.
    assign status.out_free = !out_valid_reg || out_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.finish)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.finish)
        begin
            out_accel_reg    <= upd_reg ? q_sat : accel_value_reg;
            out_acc_flag_reg <= upd_reg ? (q_ext > thr_ext) : accel_flag_reg;
            out_dec_flag_reg <= upd_reg ? (q_ext < -thr_ext) : decel_flag_reg;
            out_crank_reg    <= crank_now;
            out_coeff_reg    <= crank_now ? crank_coeff_reg : norm_coeff_reg;
            out_upd_reg      <= upd_reg;
        end
    end

    assign out_valid     = out_valid_reg;
    assign acceleration  = $signed(out_accel_reg);
    assign accelerating  = out_acc_flag_reg;
    assign decelerating  = out_dec_flag_reg;
    assign cranking      = out_crank_reg;
    assign active_coeff  = out_coeff_reg;
    assign accel_updated = out_upd_reg;

endmodule

`default_nettype wire
